// ----- design/assert_macros.svh -----
// Assertion macros for the design files of the bucketed hash multimap.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while reset is asserted.
`define HBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define HBM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBM_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/hbm_pkg.sv -----
// Package with sizes, types and operation codes of the bucketed hash multimap.
package hbm_pkg;

    localparam int BUCKET_BITS  = 8;
    localparam int BUCKET_DEPTH = 16;
    localparam int KEY_WIDTH    = 32;
    localparam int DATA_WIDTH   = 32;
    localparam int ENTRY_WIDTH  = KEY_WIDTH + DATA_WIDTH;
    localparam int NUM_BUCKETS  = 1 << BUCKET_BITS;
    localparam int SLOT_W       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W       = BUCKET_BITS + SLOT_W;
    localparam int ENTRY_DEPTH  = 1 << ADDR_W;

    typedef logic [BUCKET_BITS-1:0] bucket_t;
    typedef logic [SLOT_W-1:0]      slot_t;
    typedef logic [FILL_W-1:0]      fill_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [KEY_WIDTH-1:0]   key_t;
    typedef logic [DATA_WIDTH-1:0]  data_t;
    typedef logic [ENTRY_WIDTH-1:0] entry_t;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    // Requests from the sequencer to the fill count table.
    typedef struct packed {
        logic    rd_en;
        bucket_t rd_addr;
        logic    wr_en;
        bucket_t wr_addr;
        fill_t   wr_data;
        logic    clr;
    } fill_req_t;

    // Requests from the sequencer to the entry memory.
    typedef struct packed {
        logic   rd_en;
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
    } ram_req_t;

endpackage

// ----- design/hbm_fill_table.sv -----
// Per-bucket fill counts in a memory, with valid bits so reset and clear act at once.
module hbm_fill_table
(
    input  logic               clk,
    input  logic               rst_n,
    input  hbm_pkg::fill_req_t req,
    output hbm_pkg::fill_t     rd_fill
);

    hbm_pkg::fill_t                  fill_mem [hbm_pkg::NUM_BUCKETS];
    logic [hbm_pkg::NUM_BUCKETS-1:0] valid_reg;
    hbm_pkg::fill_t                  rd_data_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            fill_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= fill_mem[req.rd_addr];
        end
    end

    // A bucket whose valid bit is low reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_fill = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- design/hbm_entry_ram.sv -----
// Entry memory: one write and one registered read port, key in the upper half.
module hbm_entry_ram
(
    input  logic              clk,
    input  hbm_pkg::ram_req_t req,
    output hbm_pkg::entry_t   rd_data
);

    hbm_pkg::entry_t mem [hbm_pkg::ENTRY_DEPTH];
    hbm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/prefix_bucketed_hash_multimap_core.sv -----
// Top level of the bucketed hash multimap: sequencer, fill table and entry memory.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | func, key, value
//  out     | output    | out_valid / out_ready| first_found, first_value, second_found,
//          |           |                      | second_value, status
//
// One item at a time: a sequencer walks the bucket through the single read port of the
// entry memory, reading each entry and comparing its key in the next state. An insert
// moves up the entries that follow the run of its key; clear, a full bucket or an
// unused code finish without a scan. Reset clears the fill valid bits at once.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and only the end of that item's work waits for the output register to be free.
`include "assert_macros.svh"

module prefix_bucketed_hash_multimap_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  hbm_pkg::key_t          key,
    input  hbm_pkg::data_t         value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   first_found,
    output hbm_pkg::data_t         first_value,
    output logic                   second_found,
    output hbm_pkg::data_t         second_value,
    output logic                   status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_NEXT_RD,
        S_NEXT_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [1:0]         func_reg;
    hbm_pkg::key_t      key_reg;
    hbm_pkg::data_t     value_reg;
    hbm_pkg::fill_t     fill_reg;
    hbm_pkg::fill_t     idx_reg;
    hbm_pkg::fill_t     pos_reg;
    logic               found_reg;

    // Result under construction.
    logic               res_first_found_reg;
    hbm_pkg::data_t     res_first_value_reg;
    logic               res_second_found_reg;
    hbm_pkg::data_t     res_second_value_reg;
    logic               res_status_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_first_found_reg;
    hbm_pkg::data_t     out_first_value_reg;
    logic               out_second_found_reg;
    hbm_pkg::data_t     out_second_value_reg;
    logic               out_status_reg;

    hbm_pkg::fill_req_t fill_req;
    hbm_pkg::fill_t     fill_rd;
    hbm_pkg::ram_req_t  ram_req;
    hbm_pkg::entry_t    ram_rdata;

    hbm_pkg::bucket_t   bucket;
    hbm_pkg::key_t      rd_key;
    hbm_pkg::data_t     rd_data;
    hbm_pkg::fill_t     idx_inc;
    hbm_pkg::fill_t     idx_dec;
    logic               key_match;
    logic               last_slot;
    logic               out_free;

    hbm_fill_table u_fill_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fill_req),
        .rd_fill (fill_rd)
    );

    hbm_entry_ram u_entry_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    // The shared compare unit: key of the entry just read against the item's key.
    assign bucket    = key_reg[hbm_pkg::KEY_WIDTH-1 -: hbm_pkg::BUCKET_BITS];
    assign rd_key    = ram_rdata[hbm_pkg::ENTRY_WIDTH-1 -: hbm_pkg::KEY_WIDTH];
    assign rd_data   = ram_rdata[hbm_pkg::DATA_WIDTH-1:0];
    assign idx_inc   = idx_reg + hbm_pkg::fill_t'(1);
    assign idx_dec   = idx_reg - hbm_pkg::fill_t'(1);
    assign key_match = (rd_key == key_reg);
    assign last_slot = !(idx_inc < fill_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        fill_req.rd_en   = (state_reg == S_IDLE) && in_valid;
        fill_req.rd_addr = key[hbm_pkg::KEY_WIDTH-1 -: hbm_pkg::BUCKET_BITS];
        fill_req.wr_en   = (state_reg == S_WRITE);
        fill_req.wr_addr = bucket;
        fill_req.wr_data = fill_reg + hbm_pkg::fill_t'(1);
        fill_req.clr     = (state_reg == S_FILL) && (func_reg == hbm_pkg::FUNC_CLEAR);

        ram_req.rd_en    = (state_reg == S_SCAN_RD) || (state_reg == S_NEXT_RD) ||
                           (state_reg == S_SHIFT_RD);
        if (state_reg == S_SHIFT_RD)
        begin
            ram_req.rd_addr = {bucket, idx_dec[hbm_pkg::SLOT_W-1:0]};
        end
        else
        begin
            ram_req.rd_addr = {bucket, idx_reg[hbm_pkg::SLOT_W-1:0]};
        end
        ram_req.wr_en    = (state_reg == S_SHIFT_WR) || (state_reg == S_WRITE);
        if (state_reg == S_SHIFT_WR)
        begin
            ram_req.wr_addr = {bucket, idx_reg[hbm_pkg::SLOT_W-1:0]};
            ram_req.wr_data = ram_rdata;
        end
        else
        begin
            ram_req.wr_addr = {bucket, pos_reg[hbm_pkg::SLOT_W-1:0]};
            ram_req.wr_data = {key_reg, value_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            func_reg             <= '0;
            key_reg              <= '0;
            value_reg            <= '0;
            fill_reg             <= '0;
            idx_reg              <= '0;
            pos_reg              <= '0;
            found_reg            <= 1'b0;
            res_first_found_reg  <= 1'b0;
            res_first_value_reg  <= '0;
            res_second_found_reg <= 1'b0;
            res_second_value_reg <= '0;
            res_status_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
            out_first_found_reg  <= 1'b0;
            out_first_value_reg  <= '0;
            out_second_found_reg <= 1'b0;
            out_second_value_reg <= '0;
            out_status_reg       <= 1'b0;
        end
        else
        begin
            // The output register is loaded when the item finishes and emptied when taken.
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg             <= func;
                        key_reg              <= key;
                        value_reg            <= value;
                        idx_reg              <= '0;
                        found_reg            <= 1'b0;
                        res_first_found_reg  <= 1'b0;
                        res_first_value_reg  <= '0;
                        res_second_found_reg <= 1'b0;
                        res_second_value_reg <= '0;
                        res_status_reg       <= 1'b0;
                        state_reg            <= S_FILL;
                    end
                end

                S_FILL:
                begin
                    fill_reg <= fill_rd;
                    priority if (func_reg == hbm_pkg::FUNC_LOOKUP)
                    begin
                        state_reg <= (fill_rd == '0) ? S_FINISH : S_SCAN_RD;
                    end
                    else if (func_reg == hbm_pkg::FUNC_INSERT)
                    begin
                        if (fill_rd >= hbm_pkg::fill_t'(hbm_pkg::BUCKET_DEPTH))
                        begin
                            res_status_reg <= 1'b1;
                            state_reg      <= S_FINISH;
                        end
                        else if (fill_rd == '0)
                        begin
                            pos_reg   <= '0;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        // Clear acts through the fill table; the unused code does nothing.
                        state_reg <= S_FINISH;
                    end
                end

                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end

                S_SCAN_CMP:
                begin
                    if (func_reg == hbm_pkg::FUNC_LOOKUP)
                    begin
                        if (key_match)
                        begin
                            res_first_found_reg <= 1'b1;
                            res_first_value_reg <= rd_data;
                            idx_reg             <= idx_inc;
                            state_reg           <= last_slot ? S_FINISH : S_NEXT_RD;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= last_slot ? S_FINISH : S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        // Insert: the new entry goes right after the run of its key,
                        // or at the end of the bucket if the key is absent.
                        if (key_match)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (!key_match && found_reg)
                        begin
                            pos_reg   <= idx_reg;
                            idx_reg   <= fill_reg;
                            state_reg <= S_SHIFT_RD;
                        end
                        else if (last_slot)
                        begin
                            pos_reg   <= fill_reg;
                            idx_reg   <= fill_reg;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end

                S_NEXT_RD:
                begin
                    state_reg <= S_NEXT_CMP;
                end

                S_NEXT_CMP:
                begin
                    if (key_match)
                    begin
                        res_second_found_reg <= 1'b1;
                        res_second_value_reg <= rd_data;
                    end
                    state_reg <= S_FINISH;
                end

                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end

                S_SHIFT_WR:
                begin
                    // Entry at idx - 1 has just been copied to idx.
                    idx_reg   <= idx_dec;
                    state_reg <= (idx_dec > pos_reg) ? S_SHIFT_RD : S_WRITE;
                end

                S_WRITE:
                begin
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_first_found_reg  <= res_first_found_reg;
                        out_first_value_reg  <= res_first_value_reg;
                        out_second_found_reg <= res_second_found_reg;
                        out_second_value_reg <= res_second_value_reg;
                        out_status_reg       <= res_status_reg;
                        state_reg            <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign first_found  = out_first_found_reg;
    assign first_value  = out_first_value_reg;
    assign second_found = out_second_found_reg;
    assign second_value = out_second_value_reg;
    assign status       = out_status_reg;

    `HBM_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready,
                "ready after accept")
    `HBM_NEVER(a_second_needs_first, clk, rst_n,
               out_valid && second_found && !first_found, "second without first")
    `HBM_NEVER(a_refused_lookup, clk, rst_n, out_valid && status && first_found,
               "status on a lookup hit")
    `HBM_ASSERT(a_fill_bound, clk, rst_n,
                fill_req.wr_en |-> fill_req.wr_data <= hbm_pkg::fill_t'(hbm_pkg::BUCKET_DEPTH),
                "fill overflow")
    `HBM_ASSERT(a_shift_above_pos, clk, rst_n, state_reg == S_SHIFT_WR |-> idx_reg > pos_reg,
                "shift below insert slot")

endmodule

// ----- dv/tb_prefix_bucketed_hash_multimap_core.sv -----
// Self-checking testbench for the prefix-bucketed hash multimap core.
module tb_prefix_bucketed_hash_multimap_core;

    // Operation code that the block must treat as a no-op.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // The slowest item is an insert that scans and then moves up entries in a bucket
    // one short of full. The settle wait covers that with some margin.
    localparam int SETTLE_CYCLES = 80;
    // Cycles without any accepted item, on either channel, before the run is abandoned.
    // The longest legal quiet stretch is the receiver hold-off below plus one item.
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int LOW_W         = hbm_pkg::KEY_WIDTH - hbm_pkg::BUCKET_BITS;

    typedef struct packed {
        logic           first_found;
        hbm_pkg::data_t first_value;
        logic           second_found;
        hbm_pkg::data_t second_value;
        logic           status;
    } hbm_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [1:0]     func = hbm_pkg::FUNC_LOOKUP;
    hbm_pkg::key_t  key = '0;
    hbm_pkg::data_t value = '0;
    logic           out_valid;
    logic           out_ready = 1'b1;
    logic           first_found;
    hbm_pkg::data_t first_value;
    logic           second_found;
    hbm_pkg::data_t second_value;
    logic           status;

    // Shadow copy of the table. Only slots below a bucket's count are ever read,
    // so the entry arrays need no reset.
    hbm_pkg::key_t  bucket_keys  [hbm_pkg::NUM_BUCKETS][hbm_pkg::BUCKET_DEPTH];
    hbm_pkg::data_t bucket_data  [hbm_pkg::NUM_BUCKETS][hbm_pkg::BUCKET_DEPTH];
    int             bucket_count [hbm_pkg::NUM_BUCKETS] = '{default: 0};

    // Results predicted for accepted items, oldest first.
    hbm_result_t pending_results[$];
    hbm_result_t oldest_result;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_request   = 0;
    bit idle_off       = 1'b0;

    // Hot buckets and low key parts for the random phase, so that keys collide.
    hbm_pkg::bucket_t hot_bucket[3];
    logic [LOW_W-1:0] hot_low[4];

    prefix_bucketed_hash_multimap_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_found  (first_found),
        .first_value  (first_value),
        .second_found (second_found),
        .second_value (second_value),
        .status       (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one operation to the shadow table and returns the result it should give.
    function automatic hbm_result_t apply_table_op(logic [1:0] op, hbm_pkg::key_t k,
                                                   hbm_pkg::data_t v);
        hbm_result_t      r;
        hbm_pkg::bucket_t b;
        int               n;
        int               pos;
        int               i;
        r   = '0;
        b   = k[hbm_pkg::KEY_WIDTH-1 -: hbm_pkg::BUCKET_BITS];
        n   = bucket_count[b];
        pos = 0;
        case (op)
            hbm_pkg::FUNC_LOOKUP:
            begin
                while (pos < n && bucket_keys[b][pos] != k)
                    pos++;
                if (pos < n)
                begin
                    r.first_found = 1'b1;
                    r.first_value = bucket_data[b][pos];
                    // A second hit only counts when it directly follows the first.
                    if (pos + 1 < n && bucket_keys[b][pos+1] == k)
                    begin
                        r.second_found = 1'b1;
                        r.second_value = bucket_data[b][pos+1];
                    end
                end
            end
            hbm_pkg::FUNC_INSERT:
            begin
                if (n >= hbm_pkg::BUCKET_DEPTH)
                    r.status = 1'b1;
                else
                begin
                    // New entry lands right after the existing run of its key,
                    // or at the end of the bucket if the key is new.
                    while (pos < n && bucket_keys[b][pos] != k)
                        pos++;
                    while (pos < n && bucket_keys[b][pos] == k)
                        pos++;
                    for (i = n; i > pos; i--)
                    begin
                        bucket_keys[b][i] = bucket_keys[b][i-1];
                        bucket_data[b][i] = bucket_data[b][i-1];
                    end
                    bucket_keys[b][pos] = k;
                    bucket_data[b][pos] = v;
                    bucket_count[b]     = n + 1;
                end
            end
            hbm_pkg::FUNC_CLEAR:
            begin
                for (i = 0; i < hbm_pkg::NUM_BUCKETS; i++)
                    bucket_count[i] = 0;
            end
            default:
            begin
                // The unused code leaves the table alone and returns all zeros.
            end
        endcase
        return r;
    endfunction

    // Offers one item, optionally after a random idle burst, and records its
    // predicted result once the block accepts it. Valid stays high afterwards,
    // so the caller either sends again in the same step or lowers it.
    task automatic send_item(logic [1:0] op, hbm_pkg::key_t k, hbm_pkg::data_t v);
        if (!idle_off && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_table_op(op, k, v));
    endtask

    // Stops offering items until every predicted result has come back,
    // then lets the block settle.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic hbm_pkg::key_t pick_key();
        if ($urandom_range(0, 99) < 15)
            return $urandom();
        return {hot_bucket[$urandom_range(0, 2)], hot_low[$urandom_range(0, 3)]};
    endfunction

    // Extremes of key and data, duplicate runs with shifting, misses, the unused
    // code, and a clear that must hide the stale entries left in memory.
    task automatic test_directed();
        hbm_pkg::key_t dup_key;
        hbm_pkg::key_t other_key;
        dup_key   = 32'h5A00_0001;
        other_key = 32'h5A00_0002;
        send_item(hbm_pkg::FUNC_LOOKUP, 32'h0000_0000, $urandom());
        send_item(hbm_pkg::FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(hbm_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(hbm_pkg::FUNC_LOOKUP, 32'h0000_0000, $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, $urandom());
        send_item(hbm_pkg::FUNC_INSERT, dup_key, 32'hAAAA_0001);
        send_item(hbm_pkg::FUNC_INSERT, other_key, 32'hBBBB_0001);
        send_item(hbm_pkg::FUNC_INSERT, dup_key, 32'hAAAA_0002);
        send_item(hbm_pkg::FUNC_INSERT, dup_key, 32'hAAAA_0003);
        send_item(hbm_pkg::FUNC_LOOKUP, dup_key, $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, other_key, $urandom());
        send_item(hbm_pkg::FUNC_INSERT, other_key, 32'hBBBB_0002);
        send_item(hbm_pkg::FUNC_LOOKUP, other_key, $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, 32'h5A00_0003, $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, 32'h5B00_0001, $urandom());
        send_item(FUNC_UNUSED, dup_key, $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, dup_key, $urandom());
        send_item(hbm_pkg::FUNC_CLEAR, $urandom(), $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, dup_key, $urandom());
        send_item(hbm_pkg::FUNC_LOOKUP, 32'h0000_0000, $urandom());
        send_item(hbm_pkg::FUNC_INSERT, dup_key, 32'h1234_5678);
        send_item(hbm_pkg::FUNC_LOOKUP, dup_key, $urandom());
        wait_for_results();
    endtask

    // Fills one bucket to its depth, then checks that further inserts are refused
    // and that the stored runs are still found.
    task automatic test_full_bucket();
        hbm_pkg::bucket_t b;
        logic [LOW_W-1:0] lows[3];
        int               i;
        b = hbm_pkg::bucket_t'($urandom());
        foreach (lows[j])
            lows[j] = LOW_W'($urandom());
        for (i = 0; i < hbm_pkg::BUCKET_DEPTH + 2; i++)
            send_item(hbm_pkg::FUNC_INSERT, {b, lows[$urandom_range(0, 2)]}, $urandom());
        foreach (lows[j])
            send_item(hbm_pkg::FUNC_LOOKUP, {b, lows[j]}, $urandom());
        send_item(hbm_pkg::FUNC_INSERT, {b, LOW_W'($urandom())}, $urandom());
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // block fills up and drops in_ready; everything must drain in order afterwards.
    task automatic test_backpressure();
        hbm_pkg::bucket_t b;
        int               i;
        b            = hbm_pkg::bucket_t'($urandom());
        hold_request = HOLD_CYCLES;
        for (i = 0; i < 12; i++)
            send_item((i % 3 == 2) ? hbm_pkg::FUNC_LOOKUP : hbm_pkg::FUNC_INSERT,
                      {b, LOW_W'($urandom_range(0, 2))}, $urandom());
        wait_for_results();
    endtask

    // Mostly inserts and lookups on a few hot buckets and keys, with rare clears
    // and unused codes; buckets fill up and runs of duplicates form.
    task automatic test_random(int count);
        int         i;
        int         pick;
        logic [1:0] op;
        foreach (hot_bucket[j])
            hot_bucket[j] = hbm_pkg::bucket_t'($urandom());
        foreach (hot_low[j])
            hot_low[j] = LOW_W'($urandom());
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 2)
                op = hbm_pkg::FUNC_CLEAR;
            else if (pick < 8)
                op = FUNC_UNUSED;
            else if (pick < 108)
                op = hbm_pkg::FUNC_INSERT;
            else
                op = hbm_pkg::FUNC_LOOKUP;
            send_item(op, pick_key(), $urandom());
        end
        wait_for_results();
    endtask

    // Receiver: random stall bursts, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                out_ready <= 1'b1;
            end
            else if (!idle_off && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // Compares every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result with nothing outstanding");
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("first_found", oldest_result.first_found, first_found);
                check_field("first_value", oldest_result.first_value, first_value);
                check_field("second_found", oldest_result.second_found, second_found);
                check_field("second_value", oldest_result.second_value, second_value);
                check_field("status", oldest_result.status, status);
            end
        end
    end

    // Watchdog: a run that stops moving on both channels is a failure.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_full_bucket();
        test_backpressure();
        test_random(340);

        // Last part of the run at full rate on both sides.
        idle_off = 1'b1;
        test_random(50);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
